>>> sv/sse_event_stream_parser_assert.svh
// Assertion macros shared by the event stream parser modules.
`ifndef SSE_EVENT_STREAM_PARSER_ASSERT_SVH
`define SSE_EVENT_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sse parser check failed");

// Next-cycle implication, checked outside reset.
`define SSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sse parser check failed");

`endif

>>> sv/sse_pkg.sv
// Types, character codes and name-match helpers for the event stream parser.
`default_nettype none

package sse_pkg;

    // Result request kinds
    typedef enum logic [2:0] {
        KIND_DATA_BYTE    = 3'd0,
        KIND_TYPE_RESTART = 3'd1,
        KIND_TYPE_BYTE    = 3'd2,
        KIND_ID_RESTART   = 3'd3,
        KIND_ID_BYTE      = 3'd4,
        KIND_DISPATCH     = 3'd5,
        KIND_DISCARD      = 3'd6
    } t_kind;

    // Field that the current value belongs to
    typedef enum logic [1:0] {
        FIELD_NONE  = 2'd0,
        FIELD_EVENT = 2'd1,
        FIELD_DATA  = 2'd2,
        FIELD_ID    = 2'd3
    } t_field;

    // One result request handed from the parse core to the output register
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  value;
        logic        type_given;
        logic        id_given;
    } t_result;

    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;

    // Bit 0 "event", bit 1 "data", bit 2 "id"
    localparam logic [2:0] NAME_ALL     = 3'b111;
    localparam logic [2:0] NAME_LEN_MAX = 3'd7;
    localparam logic [2:0] LEN_EVENT    = 3'd5;
    localparam logic [2:0] LEN_DATA     = 3'd4;
    localparam logic [2:0] LEN_ID       = 3'd2;

    // Which candidate names still agree with byte b at position pos
    function automatic logic [2:0] name_step(input logic [2:0] pos, input logic [7:0] b);
        logic [2:0] ok;
        ok = 3'b000;
        unique case (pos)
            3'd0: begin
                ok[0] = (b == 8'h65);   // e
                ok[1] = (b == 8'h64);   // d
                ok[2] = (b == 8'h69);   // i
            end
            3'd1: begin
                ok[0] = (b == 8'h76);   // v
                ok[1] = (b == 8'h61);   // a
                ok[2] = (b == 8'h64);   // d
            end
            3'd2: begin
                ok[0] = (b == 8'h65);   // e
                ok[1] = (b == 8'h74);   // t
            end
            3'd3: begin
                ok[0] = (b == 8'h6E);   // n
                ok[1] = (b == 8'h61);   // a
            end
            3'd4: begin
                ok[0] = (b == 8'h74);   // t
            end
            default: ok = 3'b000;
        endcase
        return ok;
    endfunction

    // Field named by the bytes seen so far, none if no full match
    function automatic t_field matched_field(input logic [2:0] hits,
                                             input logic [2:0] len);
        t_field f;
        f = FIELD_NONE;
        if (hits[0] && len == LEN_EVENT) begin
            f = FIELD_EVENT;
        end else if (hits[1] && len == LEN_DATA) begin
            f = FIELD_DATA;
        end else if (hits[2] && len == LEN_ID) begin
            f = FIELD_ID;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

>>> sv/sse_parse_core.sv
// Per-byte line/field parser: state registers and the combinational step logic.
`default_nettype none

module sse_parse_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_byte,
    output logic                   o_res_valid,
    output sse_pkg::t_result       o_res
);

    logic              r_line_has_bytes, n_line_has_bytes;
    logic              r_past_colon, n_past_colon;
    logic              r_skip_space, n_skip_space;
    logic [2:0]        r_name_length, n_name_length;
    logic [2:0]        r_name_matches, n_name_matches;
    sse_pkg::t_field   r_value_field, n_value_field;
    logic              r_cr_seen, n_cr_seen;
    logic              r_data_present, n_data_present;
    logic              r_type_present, n_type_present;
    logic              r_id_present, n_id_present;

    logic              do_open;
    logic              clr_line;
    sse_pkg::t_field   open_field;
    sse_pkg::t_field   cur_match;

    assign cur_match = sse_pkg::matched_field(r_name_matches, r_name_length);

    // Step logic for one byte
    always_comb begin
        n_line_has_bytes = r_line_has_bytes;
        n_past_colon     = r_past_colon;
        n_skip_space     = r_skip_space;
        n_name_length    = r_name_length;
        n_name_matches   = r_name_matches;
        n_value_field    = r_value_field;
        n_cr_seen        = r_cr_seen;
        n_data_present   = r_data_present;
        n_type_present   = r_type_present;
        n_id_present     = r_id_present;
        o_res_valid      = 1'b0;
        o_res            = '0;
        do_open          = 1'b0;
        clr_line         = 1'b0;
        open_field       = sse_pkg::FIELD_NONE;

        if (i_step) begin
            if (i_byte == sse_pkg::CHR_LF && r_cr_seen) begin
                // LF of a CR LF pair: already handled by the CR
                n_cr_seen = 1'b0;
            end else if (i_byte == sse_pkg::CHR_LF || i_byte == sse_pkg::CHR_CR) begin
                n_cr_seen = (i_byte == sse_pkg::CHR_CR);
                clr_line  = 1'b1;
                if (!r_line_has_bytes) begin
                    // blank line: dispatch or discard the event
                    o_res_valid = 1'b1;
                    if (r_data_present) begin
                        o_res.kind       = sse_pkg::KIND_DISPATCH;
                        o_res.type_given = r_type_present;
                        o_res.id_given   = r_id_present;
                    end else begin
                        o_res.kind = sse_pkg::KIND_DISCARD;
                    end
                    n_data_present = 1'b0;
                    n_type_present = 1'b0;
                    n_id_present   = 1'b0;
                end else if (!r_past_colon) begin
                    // name without colon: empty value
                    do_open    = 1'b1;
                    open_field = cur_match;
                end
            end else begin
                n_cr_seen        = 1'b0;
                n_line_has_bytes = 1'b1;
                if (!r_past_colon) begin
                    if (i_byte == sse_pkg::CHR_COLON) begin
                        n_past_colon  = 1'b1;
                        n_skip_space  = 1'b1;
                        n_value_field = cur_match;
                        do_open       = 1'b1;
                        open_field    = cur_match;
                    end else begin
                        n_name_matches = r_name_matches
                                       & sse_pkg::name_step(r_name_length, i_byte);
                        if (r_name_length != sse_pkg::NAME_LEN_MAX) begin
                            n_name_length = r_name_length + 3'd1;
                        end
                    end
                end else if (r_skip_space && i_byte == sse_pkg::CHR_SPACE) begin
                    n_skip_space = 1'b0;
                end else begin
                    // value byte
                    n_skip_space = 1'b0;
                    o_res.value  = i_byte;
                    unique case (r_value_field)
                        sse_pkg::FIELD_EVENT: begin
                            o_res_valid = 1'b1;
                            o_res.kind  = sse_pkg::KIND_TYPE_BYTE;
                        end
                        sse_pkg::FIELD_DATA: begin
                            o_res_valid = 1'b1;
                            o_res.kind  = sse_pkg::KIND_DATA_BYTE;
                        end
                        sse_pkg::FIELD_ID: begin
                            o_res_valid = 1'b1;
                            o_res.kind  = sse_pkg::KIND_ID_BYTE;
                        end
                        default: begin
                            o_res.value = 8'h00;
                        end
                    endcase
                end
            end

            // start of a value
            if (do_open) begin
                unique case (open_field)
                    sse_pkg::FIELD_EVENT: begin
                        n_type_present = 1'b1;
                        o_res_valid    = 1'b1;
                        o_res.kind     = sse_pkg::KIND_TYPE_RESTART;
                    end
                    sse_pkg::FIELD_ID: begin
                        n_id_present = 1'b1;
                        o_res_valid  = 1'b1;
                        o_res.kind   = sse_pkg::KIND_ID_RESTART;
                    end
                    sse_pkg::FIELD_DATA: begin
                        if (r_data_present) begin
                            // join newline between data lines
                            o_res_valid = 1'b1;
                            o_res.kind  = sse_pkg::KIND_DATA_BYTE;
                            o_res.value = sse_pkg::CHR_LF;
                        end
                        n_data_present = 1'b1;
                    end
                    default: begin
                        n_data_present = r_data_present;
                    end
                endcase
            end

            // end of line
            if (clr_line) begin
                n_line_has_bytes = 1'b0;
                n_past_colon     = 1'b0;
                n_skip_space     = 1'b0;
                n_name_length    = 3'd0;
                n_name_matches   = sse_pkg::NAME_ALL;
                n_value_field    = sse_pkg::FIELD_NONE;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_has_bytes <= 1'b0;
            r_past_colon     <= 1'b0;
            r_skip_space     <= 1'b0;
            r_name_length    <= 3'd0;
            r_name_matches   <= sse_pkg::NAME_ALL;
            r_value_field    <= sse_pkg::FIELD_NONE;
            r_cr_seen        <= 1'b0;
            r_data_present   <= 1'b0;
            r_type_present   <= 1'b0;
            r_id_present     <= 1'b0;
        end else begin
            r_line_has_bytes <= n_line_has_bytes;
            r_past_colon     <= n_past_colon;
            r_skip_space     <= n_skip_space;
            r_name_length    <= n_name_length;
            r_name_matches   <= n_name_matches;
            r_value_field    <= n_value_field;
            r_cr_seen        <= n_cr_seen;
            r_data_present   <= n_data_present;
            r_type_present   <= n_type_present;
            r_id_present     <= n_id_present;
        end
    end

`include "sse_event_stream_parser_assert.svh"

    // A line that is past its colon always holds bytes (the colon itself counts)
    `SSE_ASSERT_NOW(a_colon_needs_bytes, r_past_colon, r_line_has_bytes)
    // Space skip is armed only after the colon
    `SSE_ASSERT_NOW(a_skip_after_colon, r_skip_space, r_past_colon)
    // No value field is chosen before the colon
    `SSE_ASSERT_NOW(a_field_after_colon, !r_past_colon, r_value_field == sse_pkg::FIELD_NONE)

endmodule

`default_nettype wire

>>> sv/sse_event_stream_parser.sv
// Top level of the event stream parser: input register, parse core, result register.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_byte
//  out     | o_out_valid | i_out_stall | o_result_kind, o_result_byte,
//          |             |             | o_type_given, o_id_given
//
// One byte per cycle sustained while the output is not stalled; a byte's result passes
// through the input register, then the combinational parse step into the result register.
// A byte that causes no result just updates the parser state.
// Reset is synchronous and clears all control and parser state; nothing else is swept.
// A stall on the output holds the result register and, once the input register is full,
// raises o_in_stall in the same cycle.
`default_nettype none

module sse_event_stream_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [2:0]       o_result_kind,
    output logic [7:0]       o_result_byte,
    output logic             o_type_given,
    output logic             o_id_given
);

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    sse_pkg::t_result    r_out;

    logic                out_ready;
    logic                advance;
    logic                in_take;
    logic                res_valid;
    sse_pkg::t_result    res;

    // Handshake control
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    sse_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= advance && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_result_byte = r_out.value;
    assign o_type_given  = r_out.type_given;
    assign o_id_given    = r_out.id_given;

`include "sse_event_stream_parser_assert.svh"

    // A held input byte is neither lost nor replaced while the output is blocked
    `SSE_ASSERT_NEXT(a_in_hold, r_in_valid && o_in_stall, r_in_valid && $stable(r_in_byte))
    // Flags only ride on a dispatch
    `SSE_ASSERT_NOW(a_flags_dispatch_only,
        o_out_valid && r_out.kind != sse_pkg::KIND_DISPATCH,
        !o_type_given && !o_id_given)
    // Marker kinds carry a zero byte
    `SSE_ASSERT_NOW(a_marker_zero_byte,
        o_out_valid && (r_out.kind == sse_pkg::KIND_DISPATCH ||
                        r_out.kind == sse_pkg::KIND_DISCARD ||
                        r_out.kind == sse_pkg::KIND_TYPE_RESTART ||
                        r_out.kind == sse_pkg::KIND_ID_RESTART),
        o_result_byte == 8'h00)

endmodule

`default_nettype wire
